// ===== hw/rtl/deq_pkg.sv =====
// Shared types, codes and defaults for the double-ended queue.
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 5;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    CS_IDLE,
    CS_READ
  } ctrl_state_e;

  typedef struct packed {
    op_e                        operation;
    logic signed [VALUE_W-1:0]  push_value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  pop_value;
    status_e                    status;
    logic        [COUNT_W-1:0]  count;
    logic                       is_empty;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;       // execute the request on the input port
    logic load_result;  // load the finished result of that request
    logic load_read;    // load the result of a pop from the read data
  } deq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic pop_ok;       // request is a pop that will read storage
  } deq_sts_t;

endpackage

// ===== hw/rtl/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// Controller state machine: handshakes, read wait and output valid.
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  deq_pkg::deq_sts_t sts_i,
  output deq_pkg::deq_cmd_t cmd_o
);
  import deq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_busy;

  // Output register stays occupied through this edge.
  assign out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    in_stall_o        = 1'b1;
    case (state_q)
      CS_IDLE: begin
        in_stall_o   = out_busy;
        cmd_o.accept = in_valid_i && !out_busy;
        if (cmd_o.accept) begin
          if (sts_i.pop_ok) begin
            state_d = CS_READ;
          end else begin
            cmd_o.load_result = 1'b1;
          end
        end
      end
      CS_READ: begin
        cmd_o.load_read = 1'b1;
        state_d         = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase

    if (cmd_o.load_result || cmd_o.load_read) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/deq_datapath.sv =====
// Datapath: ring indices, entry count, storage and the output register.
module deq_datapath #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  deq_pkg::in_t      in_data_i,
  input  deq_pkg::deq_cmd_t cmd_i,
  output deq_pkg::deq_sts_t sts_o,
  output deq_pkg::out_t     out_data_o
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  out_t          out_q, res;

  logic          full, empty;
  logic [AW-1:0] front_inc, front_dec, tail_slot, last_slot;
  logic [SW-1:0] tail_sum, last_sum;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [VALUE_W-1:0] rdata;

  function automatic logic [COUNT_W-1:0] to_count(input logic [CW-1:0] c);
    logic [CW+COUNT_W-1:0] ext;
    ext = {{COUNT_W{1'b0}}, c};
    return ext[COUNT_W-1:0];
  endfunction

  assign full  = (count_q == DEPTH_C);
  assign empty = (count_q == '0);

  assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;

  // front + count stays below twice the depth: one compare and subtract wraps it.
  assign tail_sum  = SW'(front_q) + SW'(count_q);
  assign last_sum  = tail_sum - 1'b1;
  always_comb begin
    tail_slot = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
    last_slot = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);
  end

  assign sts_o.pop_ok = (in_data_i.operation inside {OP_POP_FRONT, OP_POP_BACK}) && !empty;

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = tail_slot;
    raddr   = front_q;
    res     = '0;
    res.status = ST_DONE;
    case (in_data_i.operation)
      OP_PUSH_BACK: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = front_dec;
          front_d = front_dec;
          count_d = count_q + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          re      = 1'b1;
          front_d = front_inc;
          count_d = count_q - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          re      = 1'b1;
          raddr   = last_slot;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        res.status = ST_DONE;
      end
    endcase
    res.count    = to_count(count_d);
    res.is_empty = (count_d == '0);
  end

  deq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.push_value),
    .re_i    (cmd_i.accept && re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Count already holds the post-pop value when the read data lands.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      out_q <= res;
    end else if (cmd_i.load_read) begin
      out_q.pop_value <= rdata;
      out_q.status    <= ST_DONE;
      out_q.count     <= to_count(count_q);
      out_q.is_empty  <= empty;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// A push or a refused request loads its result into the output register at its transfer;
//   a successful pop first passes the registered RAM read port and then the read state.
// Throughput: one push or refused request per cycle unless the output stalls; a pop stalls the input while it reads.
// The output register takes a result while the previous one leaves in the same cycle.
// Reset clears the front index, entry count, controller state and output valid;
//   entry storage is undefined until written and gets no clearing pass.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  deq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output deq_pkg::out_t out_data_o
);
  import deq_pkg::*;

  deq_cmd_t cmd;
  deq_sts_t sts;

  // Controller: accepts a transfer when idle and the output register is free
  // (or being drained this edge), and waits in the read state for pop read data.
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: ring buffer indices with wrap at DEPTH, the count, storage
  // and the output register that holds a result until its transfer.
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== hw/rtl/deq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
module deq_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input deq_pkg::out_t out_data_o
);
  import deq_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A refused push reports a full queue.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |->
      out_data_o.count == COUNT_W'(DEPTH) && !out_data_o.is_empty &&
      out_data_o.pop_value == '0)
    else $error("full refusal with wrong count or value");

  // A refused pop reports an empty queue.
  a_empty_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |->
      out_data_o.count == '0 && out_data_o.is_empty && out_data_o.pop_value == '0)
    else $error("empty refusal with wrong fields");

  // Accept no transfer while a result is stuck on the output.
  a_no_accept_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output blocked");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the double-ended queue: directed and random requests.
module testbench;
  import deq_pkg::*;

  localparam int DEPTH            = DEPTH_DEF;
  localparam int HOLD_OFF_CYCLES  = 48;          // long receiver hold-off, in cycles
  localparam int DRAIN_WAIT_LIMIT = 5000;        // cycles allowed for each drain
  localparam int SETTLE_CYCLES    = 8;           // quiet cycles after the last result
  localparam int MAX_REPORTS      = 10;          // mismatches printed in full

  // Clock, reset and the ports of the block; every input starts at a known value.
  logic clk_i;
  logic rst_ni       = 1'b0;
  logic in_valid_i   = 1'b0;
  logic in_stall_o;
  in_t  in_data_i    = '0;
  logic out_valid_o;
  logic out_stall_i  = 1'b0;
  out_t out_data_o;

  // Shadow copy of the queue, used to predict each result.
  logic [VALUE_W-1:0] mirror_slots [DEPTH];
  int unsigned        mirror_front = 0;
  int unsigned        mirror_count = 0;

  // Results predicted at input transfers and not yet seen at the output.
  out_t awaited_outcomes [$];

  // Shared controls between the test sequence and the receiver process.
  bit idle_enable  = 1'b1;   // allow random idle bursts on both sides
  bit hold_request = 1'b0;   // ask the receiver for one long hold-off

  // Tallies for the closing summary.
  int failures      = 0;
  int pushes_seen   = 0;
  int pops_seen     = 0;
  int full_refused  = 0;
  int empty_refused = 0;
  int results_seen  = 0;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Free-running clock, period 2.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #1000000;
    $display("Timeout: %0d results still awaited", awaited_outcomes.size());
    $display("double_ended_queue: mismatch");
    $finish;
  end

  // Count a failure; print only the first few in full.
  function automatic void note_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // Apply one request to the shadow queue and return the result it must give.
  // Refused requests leave the shadow state untouched.
  function automatic out_t predict_outcome(in_t req);
    out_t        res;
    int unsigned slot;
    res        = '0;
    res.status = ST_DONE;
    case (req.operation)
      OP_PUSH_BACK: begin
        if (mirror_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot               = (mirror_front + mirror_count) % DEPTH;
          mirror_slots[slot] = req.push_value;
          mirror_count++;
        end
      end
      OP_PUSH_FRONT: begin
        if (mirror_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // Step the front back, wrapping below slot zero.
          mirror_front               = (mirror_front == 0) ? DEPTH - 1 : mirror_front - 1;
          mirror_slots[mirror_front] = req.push_value;
          mirror_count++;
        end
      end
      OP_POP_FRONT: begin
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.pop_value = mirror_slots[mirror_front];
          mirror_front  = (mirror_front + 1) % DEPTH;
          mirror_count--;
        end
      end
      default: begin
        if (mirror_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot          = (mirror_front + mirror_count - 1) % DEPTH;
          res.pop_value = mirror_slots[slot];
          mirror_count--;
        end
      end
    endcase
    res.count    = COUNT_W'(mirror_count);
    res.is_empty = (mirror_count == 0);
    return res;
  endfunction

  // Scoreboard: check the output transfer of this edge first, then record the
  // prediction for the input transfer of this edge, so a stray result can never
  // be matched against a request that was accepted in the same cycle.
  always @(posedge clk_i) begin : check_and_predict
    out_t expected;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (awaited_outcomes.size() == 0) begin
          note_failure($sformatf("Unexpected result: value %h status %0d count %0d empty %0b",
                                 out_data_o.pop_value, out_data_o.status,
                                 out_data_o.count, out_data_o.is_empty));
        end else begin
          expected = awaited_outcomes.pop_front();
          if (out_data_o.pop_value !== expected.pop_value ||
              out_data_o.status    !== expected.status    ||
              out_data_o.count     !== expected.count     ||
              out_data_o.is_empty  !== expected.is_empty) begin
            note_failure($sformatf(
              "Mismatch: value %h/%h status %0d/%0d count %0d/%0d empty %0b/%0b (exp/act)",
              expected.pop_value, out_data_o.pop_value, expected.status, out_data_o.status,
              expected.count, out_data_o.count, expected.is_empty, out_data_o.is_empty));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected = predict_outcome(in_data_i);
        if (in_data_i.operation inside {OP_PUSH_BACK, OP_PUSH_FRONT}) begin
          pushes_seen++;
        end else begin
          pops_seen++;
        end
        if (expected.status == ST_FULL) full_refused++;
        if (expected.status == ST_EMPTY) empty_refused++;
        awaited_outcomes.push_back(expected);
      end
    end
  end

  // Receiver: random stall bursts, or one long hold-off on request.
  // At most one assignment to the stall per clock edge.
  initial begin : receiver
    int burst_left;
    burst_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        // Hold off for a long stretch while the sender keeps offering transfers.
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        burst_left = 0;
      end else if (!idle_enable || !rst_ni) begin
        out_stall_i <= 1'b0;
        burst_left = 0;
      end else if (burst_left > 0) begin
        out_stall_i <= 1'b1;
        burst_left--;
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        burst_left = $urandom_range(1, 6) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one request and hold it until the block takes the transfer.
  // Called at a clock edge; returns at the edge of the transfer.
  task automatic send_request(input op_e op, input logic [VALUE_W-1:0] value);
    in_t req;
    req.operation  = op;
    req.push_value = value;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      // Drop valid for a short random gap before this transfer.
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  // Random words half the time; otherwise the signed extremes, zero or all-ones.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // One random request; push_pct sets how often it is a push.
  task automatic send_random(input int push_pct);
    op_e op;
    if ($urandom_range(0, 99) < push_pct) begin
      op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else begin
      op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    end
    send_request(op, pick_value());
  endtask

  // Lower valid and wait until every predicted result has been checked or the drain limit runs out.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    for (int k = 0; k < DRAIN_WAIT_LIMIT && awaited_outcomes.size() != 0; k++) begin
      @(posedge clk_i);
    end
  endtask

  // Pops on an empty queue must be refused from either end.
  task automatic test_refused_on_empty();
    send_request(OP_POP_FRONT, 32'h1234_5678);
    send_request(OP_POP_BACK, 32'hffff_ffff);
  endtask

  // Fill from both ends, corner values first, then push into a full queue.
  // The first push at the front wraps the front index below slot zero.
  task automatic test_fill_to_capacity();
    logic [VALUE_W-1:0] corners [8];
    logic [VALUE_W-1:0] value;
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                32'h0000_0001, 32'hffff_fffe, 32'h5555_5555, 32'haaaa_aaaa};
    for (int i = 0; i < DEPTH; i++) begin
      value = (i < 8) ? corners[i] : $urandom;
      send_request((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, value);
    end
    send_request(OP_PUSH_BACK, 32'hdead_beef);
    send_request(OP_PUSH_FRONT, 32'h0bad_f00d);
  endtask

  // Take entries off both ends of a full queue.
  task automatic test_pop_both_ends();
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_POP_FRONT, 32'hffff_ffff);
    send_request(OP_POP_BACK, 32'hffff_ffff);
  endtask

  // Random traffic in runs that lean toward filling, draining or neither,
  // so the queue keeps hitting full and empty and the indices wrap often.
  task automatic test_random_traffic(input int num_items);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < num_items; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      send_random(push_pct);
    end
  endtask

  // Hold the output off for a long stretch while requests keep coming, so the
  // block fills its output stage and stalls its input.
  task automatic test_output_hold_off(input int num_items);
    hold_request = 1'b1;
    for (int i = 0; i < num_items; i++) begin
      send_random(50);
    end
  endtask

  // Pause the sender until every result is back, then resume.
  task automatic test_pause_until_drained(input int num_items);
    for (int i = 0; i < num_items; i++) begin
      send_random(60);
    end
    wait_for_drain();
    for (int i = 0; i < num_items; i++) begin
      send_random(40);
    end
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_steady_stream(input int num_items);
    idle_enable = 1'b0;
    for (int i = 0; i < num_items; i++) begin
      send_random(50);
    end
  endtask

  // Test sequence: reset once, run each test in turn, then drain and report.
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_refused_on_empty();
    test_fill_to_capacity();
    test_pop_both_ends();
    test_random_traffic(1500);
    test_output_hold_off(32);
    test_pause_until_drained(20);
    test_steady_stream(120);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_outcomes.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", awaited_outcomes.size()));
    end

    $display("Covered %0d requests (%0d pushes, %0d pops): %0d refused full, %0d refused empty.",
             pushes_seen + pops_seen, pushes_seen, pops_seen, full_refused, empty_refused);
    $display("Checked %0d results with random idling, a %0d-cycle output hold-off and a drain pause.",
             results_seen, HOLD_OFF_CYCLES);
    if (failures == 0) begin
      $display("double_ended_queue: match");
    end else begin
      $display("Failures: %0d", failures);
      $display("double_ended_queue: mismatch");
    end
    $finish;
  end

endmodule
